FILE: src/ffga_pkg.sv
// Shared types and constants of the first-fit gate allocator.
`default_nettype none
package ffga_pkg;

    localparam int TIME_W = 32;
    localparam int CNT_W  = 16;
    localparam int IDX_W  = 7;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [TIME_W-1:0] busy_until;
        logic [CNT_W-1:0]  use_count;
    } t_entry;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit_hit;
        logic commit_open;
        logic commit_ovf;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic hit;
        logic exhausted;
        logic full;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: src/ffga_if.sv
// Request and result channel interfaces of the first-fit gate allocator.
`default_nettype none
interface ffga_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_time;
    logic [31:0] end_time;

    modport source (output valid, output start_time, output end_time, input ready);
    modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface ffga_res_if;
    logic        valid;
    logic        ready;
    logic [6:0]  gate_index;
    logic [15:0] gate_use_count;
    logic        overflow;

    modport source (output valid, output gate_index, output gate_use_count,
                    output overflow, input ready);
    modport sink   (input valid, input gate_index, input gate_use_count,
                    input overflow, output ready);
endinterface
`default_nettype wire

FILE: src/ffga_ctrl.sv
// Controller state machine of the first-fit gate allocator.
`default_nettype none
module ffga_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire ffga_pkg::t_sts i_sts,
    output ffga_pkg::t_cmd    o_cmd
);
    import ffga_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    // hold the hit entry until the result register frees up
                    if (i_sts.out_free) begin
                        o_cmd.commit_hit = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.exhausted) begin
                    if (i_sts.out_free) begin
                        o_cmd.commit_ovf  = i_sts.full;
                        o_cmd.commit_open = !i_sts.full;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.scan, o_cmd.commit_hit, o_cmd.commit_open,
                  o_cmd.commit_ovf}))
        else $error("ffga_ctrl: more than one command at once");

    a_commit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit_hit || o_cmd.commit_open || o_cmd.commit_ovf) |=> o_in_ready)
        else $error("ffga_ctrl: not ready after a commit");

endmodule
`default_nettype wire

FILE: src/ffga_dp.sv
// Datapath of the first-fit gate allocator: gate table, scan pointer, result register.
`default_nettype none
module ffga_dp #(
    parameter int GATE_COUNT = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ffga_pkg::t_cmd                i_cmd,
    output ffga_pkg::t_sts                     o_sts,
    input  wire logic [ffga_pkg::TIME_W-1:0]   i_start_time,
    input  wire logic [ffga_pkg::TIME_W-1:0]   i_end_time,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [ffga_pkg::IDX_W-1:0]         o_gate_index,
    output logic [ffga_pkg::CNT_W-1:0]         o_gate_use_count,
    output logic                               o_overflow
);
    import ffga_pkg::*;

    localparam int AW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
    localparam int CW = $clog2(GATE_COUNT + 1);
    localparam int GW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(GATE_COUNT);

    t_entry r_mem [GATE_COUNT];

    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_end;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_open;
    t_entry            r_q;
    logic              r_q_vld;
    logic [AW-1:0]     r_q_idx;

    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_gate;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_ovf;

    logic              w_hit;
    logic              w_rd_en;
    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_entry            w_wr_data;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [GW-1:0]     w_gate_hit;
    logic [GW-1:0]     w_gate_open;
    logic              w_commit;

    assign w_hit     = r_q_vld && (r_q.busy_until < r_start);
    assign w_rd_en   = i_cmd.scan && (r_ptr < r_open);
    assign w_cnt_inc = (r_q.use_count == CNT_MAX) ? CNT_MAX : r_q.use_count + 1'b1;
    assign w_gate_hit  = GW'(r_q_idx) + GW'(1);
    assign w_gate_open = GW'(r_open) + GW'(1);
    assign w_commit  = i_cmd.commit_hit || i_cmd.commit_open || i_cmd.commit_ovf;

    assign w_wr_en   = i_cmd.commit_hit || i_cmd.commit_open;
    assign w_wr_addr = i_cmd.commit_hit ? r_q_idx : r_open[AW-1:0];
    always_comb begin
        w_wr_data.busy_until = r_end;
        w_wr_data.use_count  = i_cmd.commit_hit ? w_cnt_inc : CNT_W'(1);
    end

    assign o_sts.hit       = w_hit;
    assign o_sts.exhausted = (r_ptr == r_open) && !w_hit;
    assign o_sts.full      = (r_open == FULL_CNT);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // gate table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_q <= r_mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_start_time;
            r_end   <= i_end_time;
        end
        if (w_rd_en) begin
            r_q_idx <= r_ptr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_q_vld <= 1'b0;
            r_open  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ptr   <= '0;
                r_q_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_q_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (i_cmd.commit_open) begin
                r_open <= r_open + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_hit) begin
            r_out_gate <= w_gate_hit[IDX_W-1:0];
            r_out_cnt  <= w_cnt_inc;
            r_out_ovf  <= 1'b0;
        end else if (i_cmd.commit_open) begin
            r_out_gate <= w_gate_open[IDX_W-1:0];
            r_out_cnt  <= CNT_W'(1);
            r_out_ovf  <= 1'b0;
        end else if (i_cmd.commit_ovf) begin
            r_out_gate <= '0;
            r_out_cnt  <= '0;
            r_out_ovf  <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_gate_index     = r_out_gate;
    assign o_gate_use_count = r_out_cnt;
    assign o_overflow       = r_out_ovf;

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= FULL_CNT)
        else $error("ffga_dp: open gate count beyond table depth");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_open)
        else $error("ffga_dp: scan pointer past the open gates");

    a_ovf_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_ovf |=> (o_overflow && o_gate_index == '0 && o_gate_use_count == '0))
        else $error("ffga_dp: overflow result with nonzero fields");

    a_open_only_full_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_ovf |-> (r_open == FULL_CNT))
        else $error("ffga_dp: overflow reported with a closed gate left");

endmodule
`default_nettype wire

FILE: src/first_fit_gate_allocator.sv
// Top level of the first-fit gate allocator.
//
// Requests (start_time, end_time) arrive on i_req in nondecreasing start order;
// there is no sorting and no order check. Each request goes to the lowest-numbered
// open gate whose busy-until time is strictly below start_time; that gate takes
// end_time as its new busy-until and counts one more use (saturating at 65535).
// With no such gate a new gate opens with a use count of one; once all GATE_COUNT
// gates are open and busy the request is dropped and a word with overflow set,
// gate_index 0 and gate_use_count 0 is returned. Exactly one result word leaves on
// o_res per request word. Gate numbers start at 1 and keep their low 7 bits only.
// Timing: the gate table is a single memory with one registered read port, so the
// scan reads one gate per cycle. A commit waits while the output register still
// holds a word that has not been taken. A new request is accepted in the cycle
// after a commit, while the previous result may still sit in the output register
// waiting to be taken. No clearing pass runs after reset: a gate's entry is
// written when it opens.
`default_nettype none
module first_fit_gate_allocator #(
    parameter int GATE_COUNT = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ffga_req_if.sink    i_req,
    ffga_res_if.source  o_res
);
    import ffga_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // controller: accept a word, step the scan, pick the commit kind
    ffga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: gate table, scan pointer, open count and result register
    ffga_dp #(
        .GATE_COUNT (GATE_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_start_time     (i_req.start_time),
        .i_end_time       (i_req.end_time),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_gate_index     (o_res.gate_index),
        .o_gate_use_count (o_res.gate_use_count),
        .o_overflow       (o_res.overflow)
    );

    assign i_req.ready = w_in_ready;

endmodule
`default_nettype wire

FILE: sim/ffga_alloc_checker.sv
// Checker that predicts and compares the gate allocator's result words.
`default_nettype none
module ffga_alloc_checker #(
    parameter int GATE_COUNT = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ffga_req_if   i_req,
    ffga_res_if   i_res,
    output int    o_error_count,
    output int    o_outstanding
);
    import ffga_pkg::*;

    localparam int PEND_DEPTH = 16;

    typedef struct packed {
        logic [IDX_W-1:0] gate_index;
        logic [CNT_W-1:0] gate_use_count;
        logic             overflow;
    } t_grant_word;

    // Shadow gate table; busy times are only read for open gates.
    logic [TIME_W-1:0] gate_busy_until [GATE_COUNT];
    logic [CNT_W-1:0]  gate_uses       [GATE_COUNT];
    int                gates_open;

    // Predicted words in request order.
    t_grant_word       pending_grants [PEND_DEPTH];
    logic [3:0]        pend_wr_ptr;
    logic [3:0]        pend_rd_ptr;
    int                pend_count;
    int                mismatch_count;

    // First fit: lowest open gate that frees strictly before the start, else open one.
    function automatic t_grant_word allocate_gate(input logic [TIME_W-1:0] start_t,
                                                  input logic [TIME_W-1:0] end_t);
        t_grant_word grant;
        int          pick;
        pick = -1;
        for (int g = 0; g < gates_open; g++) begin
            if (pick < 0 && gate_busy_until[g] < start_t) begin
                pick = g;
            end
        end
        if (pick < 0) begin
            if (gates_open >= GATE_COUNT) begin
                grant.gate_index     = '0;
                grant.gate_use_count = '0;
                grant.overflow       = 1'b1;
                return grant;
            end
            pick = gates_open;
            gates_open++;
            gate_uses[pick] = '0;
        end
        gate_busy_until[pick] = end_t;
        if (gate_uses[pick] != CNT_MAX) begin
            gate_uses[pick] = gate_uses[pick] + 1'b1;
        end
        grant.gate_index     = IDX_W'(pick + 1);
        grant.gate_use_count = gate_uses[pick];
        grant.overflow       = 1'b0;
        return grant;
    endfunction

    always @(posedge i_clk) begin
        t_grant_word want;
        if (!i_rst_n) begin
            gates_open = 0;
            for (int g = 0; g < GATE_COUNT; g++) begin
                gate_uses[g] = '0;
            end
            pend_wr_ptr    = '0;
            pend_rd_ptr    = '0;
            pend_count     = 0;
            mismatch_count = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (pend_count >= PEND_DEPTH) begin
                    $error("too many request words in flight");
                    mismatch_count++;
                end else begin
                    pending_grants[pend_wr_ptr] = allocate_gate(i_req.start_time,
                                                                i_req.end_time);
                    pend_wr_ptr = pend_wr_ptr + 4'd1;
                    pend_count++;
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (pend_count == 0) begin
                    $error("unexpected result word: gate_index %0d gate_use_count %0d overflow %0b",
                           i_res.gate_index, i_res.gate_use_count, i_res.overflow);
                    mismatch_count++;
                end else begin
                    want        = pending_grants[pend_rd_ptr];
                    pend_rd_ptr = pend_rd_ptr + 4'd1;
                    pend_count--;
                    if (i_res.gate_index !== want.gate_index) begin
                        $error("gate_index: expected %0d, got %0d",
                               want.gate_index, i_res.gate_index);
                        mismatch_count++;
                    end
                    if (i_res.gate_use_count !== want.gate_use_count) begin
                        $error("gate_use_count: expected %0d, got %0d",
                               want.gate_use_count, i_res.gate_use_count);
                        mismatch_count++;
                    end
                    if (i_res.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, i_res.overflow);
                        mismatch_count++;
                    end
                end
            end
        end
        o_error_count <= mismatch_count;
        o_outstanding <= pend_count;
    end

endmodule
`default_nettype wire

FILE: sim/first_fit_gate_allocator_tb.sv
// Stimulus, handshake pacing and verdict for the first-fit gate allocator.
`default_nettype none
module first_fit_gate_allocator_tb;

    localparam int GATE_COUNT = 64;
    localparam int LONG_HOLD  = 600;
    // Slowest credible run, taken four times over: every word may scan all gates
    // and wait out long stalls on both sides.
    localparam int CYCLE_LIMIT = 4 * (1400 * (GATE_COUNT + 40) + LONG_HOLD);

    logic i_clk;
    logic i_rst_n;

    ffga_req_if req_bus ();
    ffga_res_if res_bus ();

    int   error_count;
    int   outstanding;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic long_hold_req;
    // Running schedule time; requests mostly start at or after it.
    logic [31:0] sched_time;

    first_fit_gate_allocator #(
        .GATE_COUNT (GATE_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    ffga_alloc_checker #(
        .GATE_COUNT (GATE_COUNT)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .i_res         (res_bus),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs or results go missing.
    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request so the
    // output register fills and the block has to stall its request input.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one request word; hold it until the block takes it. Valid stays high on
    // return so back-to-back words need no extra edge.
    task automatic offer(input logic [31:0] start_t, input logic [31:0] end_t);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.start_time <= start_t;
        req_bus.end_time   <= end_t;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Random traffic: mostly sorted schedules with random content, some dense
    // bursts that can push every gate busy into overflow, and a little noise
    // (out-of-order starts, huge starts, ends before starts).
    task automatic run_traffic(input int budget);
        int          sent;
        int          kind;
        int          len;
        logic [31:0] dur;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    // Keep noisy ends near the schedule so gates stay usable.
                    if ($urandom_range(0, 1) == 0) begin
                        offer($urandom(), sched_time - $urandom_range(0, 50));
                    end else begin
                        offer(sched_time - $urandom_range(0, 200),
                              sched_time + $urandom_range(0, 20));
                    end
                end
            end else if (kind < 22) begin
                len = $urandom_range(50, 80);
                for (int k = 0; k < len; k++) begin
                    offer(sched_time, sched_time + 200 + $urandom_range(0, 300));
                end
                sched_time += 600;
            end else begin
                len = $urandom_range(1, 40);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        sched_time += $urandom_range(1, 8);
                    end
                    if ($urandom_range(0, 7) == 0) begin
                        dur = $urandom_range(60, 3000);
                    end else begin
                        dur = $urandom_range(0, 60);
                    end
                    offer(sched_time, sched_time + dur);
                end
            end
            sent += len;
            sched_time += $urandom_range(0, 40);
        end
    endtask

    initial begin
        req_bus.valid      = 1'b0;
        req_bus.start_time = '0;
        req_bus.end_time   = '0;
        long_hold_req      = 1'b0;
        tx_idle_pct        = 12;
        rx_idle_pct        = 69;
        sched_time         = 32'd2000;
        i_rst_n            = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words, sender idles lightly, receiver heavily.
        offer(32'd0, 32'd0);                    // zero start opens gate 1
        offer(32'd0, 32'hFFFF_FFFF);            // gate 1 not strictly free: open gate 2,
                                                // busy forever after
        offer(32'd1, 32'd5);                    // reuse gate 1
        offer(32'd1, 32'd0);                    // end before start, opens gate 3
        offer(32'd2, 32'd3);                    // gate 3 frees at 0
        offer(32'd3, 32'd3);                    // gate 3 busy until exactly 3: open gate 4
        offer(32'd4, 32'd10);                   // gate 3 again
        offer(32'd2, 32'd7);                    // out of order start, opens gate 5
        // Dense burst: fill the free gates, open the rest, then overflow.
        repeat (66) offer(32'd100, 32'd1100);
        offer(32'd1100, 32'd1200);              // every gate but gate 2 busy until exactly 1100
        offer(32'd1101, 32'd1200);              // first gate frees again
        drain_results();

        run_traffic(430);
        drain_results();

        tx_idle_pct = 69;
        rx_idle_pct = 12;
        run_traffic(430);
        drain_results();

        // No idling from here on; hold the result side off while words keep coming.
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        long_hold_req = 1'b1;
        run_traffic(210);
        drain_results();

        repeat (GATE_COUNT + 10) @(posedge i_clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
